// ===== design/assert_macros.svh =====
// concurrent assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== design/lpm_pkg.sv =====
`default_nettype none

package lpm_pkg;

    localparam int SCR_W      = 13;
    localparam int PIX_W      = 5;
    localparam int COORD_W    = 14;
    localparam int PTR_W      = 12;
    localparam int VIEW_W     = 13;
    localparam int OFS_W      = 12;
    localparam int CFG_DATA_W = 13;

    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 13;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W);
    localparam int DIV_CNT_W  = $clog2(PROD_W);

    localparam int COORD_MAX  = 4095;

    localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST  = 13'd256;
    localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST = 13'd240;
    localparam logic [PIX_W-1:0]  PIXEL_SIZE_RST    = 5'd1;
    localparam logic [VIEW_W-1:0] WINDOW_WIDTH_RST  = 13'd256;
    localparam logic [VIEW_W-1:0] WINDOW_HEIGHT_RST = 13'd240;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_PIXEL_WIDTH   = 2'd2,
        CFG_PIXEL_HEIGHT  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_RESIZE  = 1'b0,
        MODE_POINTER = 1'b1
    } mode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// ===== design/lpm_in_if.sv =====
`default_nettype none

interface lpm_in_if;
    import lpm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;

    modport source (output valid, mode, x_coord, y_coord, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, output ready);
endinterface

`default_nettype wire

// ===== design/lpm_out_if.sv =====
`default_nettype none

interface lpm_out_if;
    import lpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [PTR_W-1:0]  screen_x;
    logic [PTR_W-1:0]  screen_y;
    logic [OFS_W-1:0]  view_left;
    logic [OFS_W-1:0]  view_top;
    logic [VIEW_W-1:0] view_width;
    logic [VIEW_W-1:0] view_height;

    modport source (output valid, screen_x, screen_y, view_left, view_top,
                    view_width, view_height, input ready);
    modport sink   (input valid, screen_x, screen_y, view_left, view_top,
                    view_width, view_height, output ready);
endinterface

`default_nettype wire

// ===== design/lpm_mul.sv =====
`default_nettype none

module lpm_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpm_pkg::MUL_A_W-1:0] a,
    input  logic [lpm_pkg::MUL_B_W-1:0] b,
    output lpm_pkg::unit_stat_t         stat,
    output logic [lpm_pkg::PROD_W-1:0]  prod
);
    import lpm_pkg::*;

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W-1:0]   hi_reg, hi_next;
    logic [MUL_B_W-1:0]   lo_reg, lo_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_A_W:0]     sum;

    // one multiplier bit per cycle, product bits shift down into lo
    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[MUL_A_W:1];
            lo_next  = {sum[0], lo_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== design/lpm_div.sv =====
`default_nettype none

module lpm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lpm_pkg::PROD_W-1:0]  num,
    input  logic [lpm_pkg::MUL_A_W-1:0] den,
    output lpm_pkg::unit_stat_t         stat,
    output logic [lpm_pkg::PROD_W-1:0]  quo
);
    import lpm_pkg::*;

    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [MUL_A_W-1:0]   rem_reg, rem_next;
    logic [MUL_A_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_A_W:0]     trial;
    logic [MUL_A_W:0]     diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? diff[MUL_A_W-1:0] : trial[MUL_A_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

// ===== design/letterbox_pointer_mapper.sv =====
// channel  dir  handshake     payload
// evt      in   valid/ready   mode, x_coord, y_coord
// res      out  valid/ready   screen_x, screen_y, view_left, view_top,
//                             view_width, view_height
// cfg      in   cfg_wr_en     cfg_index, cfg_data
//
// resize: a height limited viewport takes a second multiply and divide;
//   pointer: an axis may skip its multiply and divide
// run time is set by the shared 13-step serial multiplier and the shared
//   31-step restoring divider, used one after the other for every product
//   and quotient
// async reset loads the register and state reset values, no clearing pass
// a new event is taken while a result still waits in the output register;
//   the sequencer holds before loading it until that result is taken
`default_nettype none
`include "assert_macros.svh"

module letterbox_pointer_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    lpm_in_if.sink                         evt,
    lpm_out_if.source                      res,
    input  logic                           cfg_wr_en,
    input  lpm_pkg::cfg_index_t            cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lpm_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_VW   = 15'h0002,
        ST_VH   = 15'h0004,
        ST_HMUL = 15'h0008,
        ST_HDIV = 15'h0010,
        ST_WMUL = 15'h0020,
        ST_WDIV = 15'h0040,
        ST_FIT  = 15'h0080,
        ST_XCHK = 15'h0100,
        ST_XMUL = 15'h0200,
        ST_XDIV = 15'h0400,
        ST_YCHK = 15'h0800,
        ST_YMUL = 15'h1000,
        ST_YDIV = 15'h2000,
        ST_OUT  = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic mul_start_reg, mul_start_next;
    logic div_start_reg, div_start_next;

    logic [SCR_W-1:0]  screen_width_reg, screen_width_next;
    logic [SCR_W-1:0]  screen_height_reg, screen_height_next;
    logic [PIX_W-1:0]  pixel_width_reg, pixel_width_next;
    logic [PIX_W-1:0]  pixel_height_reg, pixel_height_next;

    logic [VIEW_W-1:0] win_w_reg, win_w_next;
    logic [VIEW_W-1:0] win_h_reg, win_h_next;
    logic [OFS_W-1:0]  view_left_reg, view_left_next;
    logic [OFS_W-1:0]  view_top_reg, view_top_next;
    logic [VIEW_W-1:0] view_w_reg, view_w_next;
    logic [VIEW_W-1:0] view_h_reg, view_h_next;
    logic [PTR_W-1:0]  ptr_x_reg, ptr_x_next;
    logic [PTR_W-1:0]  ptr_y_reg, ptr_y_next;
    logic              out_valid_reg, out_valid_next;

    logic [MUL_A_W-1:0] vw_tot_reg, vw_tot_next;
    logic [MUL_A_W-1:0] vh_tot_reg, vh_tot_next;
    logic [COORD_W-1:0] pos_x_reg, pos_x_next;
    logic [COORD_W-1:0] pos_y_reg, pos_y_next;
    logic               out_load;

    logic [PTR_W-1:0]  out_x_reg, out_y_reg;
    logic [OFS_W-1:0]  out_left_reg, out_top_reg;
    logic [VIEW_W-1:0] out_w_reg, out_h_reg;

    logic [SCR_W-1:0]   sw_eff, sh_eff;
    logic [PIX_W-1:0]   pw_eff, ph_eff;
    logic [COORD_W:0]   dx, dy;
    logic [VIEW_W-1:0]  span_x, span_y;
    logic               skip_x, skip_y;
    logic [VIEW_W-1:0]  free_w, free_h;
    logic [VIEW_W-1:0]  evt_w, evt_h;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [MUL_A_W-1:0] div_den;
    logic [PROD_W-1:0]  div_quo;
    unit_stat_t         mul_stat, div_stat;

    function automatic logic [PTR_W-1:0] clamp_coord(
        input logic [PROD_W-1:0] q,
        input logic [SCR_W-1:0]  scr
    );
        logic [PROD_W-1:0] lim;
        lim = q;
        if (q >= PROD_W'(scr))
        begin
            lim = PROD_W'(scr - SCR_W'(1));
        end
        if (lim > PROD_W'(COORD_MAX))
        begin
            lim = PROD_W'(COORD_MAX);
        end
        return lim[PTR_W-1:0];
    endfunction

    lpm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    lpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (mul_prod),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // operand preparation
    always_comb
    begin
        sw_eff = (screen_width_reg == '0) ? SCR_W'(1) : screen_width_reg;
        sh_eff = (screen_height_reg == '0) ? SCR_W'(1) : screen_height_reg;
        pw_eff = (pixel_width_reg == '0) ? PIX_W'(1) : pixel_width_reg;
        ph_eff = (pixel_height_reg == '0) ? PIX_W'(1) : pixel_height_reg;

        evt_w = (evt.x_coord[COORD_W-1] || evt.x_coord == '0) ? VIEW_W'(1)
                                                               : evt.x_coord[VIEW_W-1:0];
        evt_h = (evt.y_coord[COORD_W-1] || evt.y_coord == '0) ? VIEW_W'(1)
                                                               : evt.y_coord[VIEW_W-1:0];

        dx     = {pos_x_reg[COORD_W-1], pos_x_reg} - (COORD_W+1)'(view_left_reg);
        dy     = {pos_y_reg[COORD_W-1], pos_y_reg} - (COORD_W+1)'(view_top_reg);
        span_x = win_w_reg - {view_left_reg, 1'b0};
        span_y = win_h_reg - {view_top_reg, 1'b0};
        skip_x = dx[COORD_W] || dx == '0 || span_x == '0 || screen_width_reg == '0;
        skip_y = dy[COORD_W] || dy == '0 || span_y == '0 || screen_height_reg == '0;

        free_w = win_w_reg - view_w_reg;
        free_h = win_h_reg - view_h_reg;

        mul_a   = '0;
        mul_b   = '0;
        div_den = '0;
        unique case (state_reg)
            ST_VW:
            begin
                mul_a = MUL_A_W'(sw_eff);
                mul_b = MUL_B_W'(pw_eff);
            end
            ST_VH:
            begin
                mul_a = MUL_A_W'(sh_eff);
                mul_b = MUL_B_W'(ph_eff);
            end
            ST_HMUL:
            begin
                mul_a = vh_tot_reg;
                mul_b = win_w_reg;
            end
            ST_WMUL:
            begin
                mul_a = vw_tot_reg;
                mul_b = win_h_reg;
            end
            ST_XMUL:
            begin
                mul_a = MUL_A_W'(screen_width_reg);
                mul_b = dx[MUL_B_W-1:0];
            end
            ST_YMUL:
            begin
                mul_a = MUL_A_W'(screen_height_reg);
                mul_b = dy[MUL_B_W-1:0];
            end
            ST_HDIV: div_den = vw_tot_reg;
            ST_WDIV: div_den = vh_tot_reg;
            ST_XDIV: div_den = MUL_A_W'(span_x);
            ST_YDIV: div_den = MUL_A_W'(span_y);
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                div_den = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        pixel_width_next   = pixel_width_reg;
        pixel_height_next  = pixel_height_reg;
        win_w_next         = win_w_reg;
        win_h_next         = win_h_reg;
        view_left_next     = view_left_reg;
        view_top_next      = view_top_reg;
        view_w_next        = view_w_reg;
        view_h_next        = view_h_reg;
        ptr_x_next         = ptr_x_reg;
        ptr_y_next         = ptr_y_reg;
        vw_tot_next        = vw_tot_reg;
        vh_tot_next        = vh_tot_reg;
        pos_x_next         = pos_x_reg;
        pos_y_next         = pos_y_reg;
        out_valid_next     = out_valid_reg;
        out_load           = 1'b0;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_next  = cfg_data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_data[SCR_W-1:0];
                CFG_PIXEL_WIDTH:   pixel_width_next   = cfg_data[PIX_W-1:0];
                CFG_PIXEL_HEIGHT:  pixel_height_next  = cfg_data[PIX_W-1:0];
            endcase
        end

        if (res.valid && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    if (evt.mode == MODE_RESIZE)
                    begin
                        win_w_next = evt_w;
                        win_h_next = evt_h;
                        state_next = ST_VW;
                    end
                    else
                    begin
                        pos_x_next = evt.x_coord;
                        pos_y_next = evt.y_coord;
                        state_next = ST_XCHK;
                    end
                end
            end
            ST_VW:
            begin
                if (mul_stat.done)
                begin
                    vw_tot_next = mul_prod[MUL_A_W-1:0];
                    state_next  = ST_VH;
                end
            end
            ST_VH:
            begin
                if (mul_stat.done)
                begin
                    vh_tot_next = mul_prod[MUL_A_W-1:0];
                    state_next  = ST_HMUL;
                end
            end
            ST_HMUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_HDIV;
                end
            end
            ST_HDIV:
            begin
                if (div_stat.done)
                begin
                    if (div_quo > PROD_W'(win_h_reg))
                    begin
                        state_next = ST_WMUL;
                    end
                    else
                    begin
                        view_w_next = win_w_reg;
                        view_h_next = div_quo[VIEW_W-1:0];
                        state_next  = ST_FIT;
                    end
                end
            end
            ST_WMUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_WDIV;
                end
            end
            ST_WDIV:
            begin
                if (div_stat.done)
                begin
                    view_w_next = div_quo[VIEW_W-1:0];
                    view_h_next = win_h_reg;
                    state_next  = ST_FIT;
                end
            end
            ST_FIT:
            begin
                view_left_next = free_w[VIEW_W-1:1];
                view_top_next  = free_h[VIEW_W-1:1];
                state_next     = ST_OUT;
            end
            ST_XCHK:
            begin
                if (skip_x)
                begin
                    ptr_x_next = '0;
                    state_next = ST_YCHK;
                end
                else
                begin
                    state_next = ST_XMUL;
                end
            end
            ST_XMUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_XDIV;
                end
            end
            ST_XDIV:
            begin
                if (div_stat.done)
                begin
                    ptr_x_next = clamp_coord(div_quo, screen_width_reg);
                    state_next = ST_YCHK;
                end
            end
            ST_YCHK:
            begin
                if (skip_y)
                begin
                    ptr_y_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_YMUL;
                end
            end
            ST_YMUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_YDIV;
                end
            end
            ST_YDIV:
            begin
                if (div_stat.done)
                begin
                    ptr_y_next = clamp_coord(div_quo, screen_height_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mul_start_next = (state_next != state_reg) &&
                         (state_next == ST_VW || state_next == ST_VH ||
                          state_next == ST_HMUL || state_next == ST_WMUL ||
                          state_next == ST_XMUL || state_next == ST_YMUL);
        div_start_next = (state_next != state_reg) &&
                         (state_next == ST_HDIV || state_next == ST_WDIV ||
                          state_next == ST_XDIV || state_next == ST_YDIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            mul_start_reg     <= 1'b0;
            div_start_reg     <= 1'b0;
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            pixel_width_reg   <= PIXEL_SIZE_RST;
            pixel_height_reg  <= PIXEL_SIZE_RST;
            win_w_reg         <= WINDOW_WIDTH_RST;
            win_h_reg         <= WINDOW_HEIGHT_RST;
            view_left_reg     <= '0;
            view_top_reg      <= '0;
            view_w_reg        <= WINDOW_WIDTH_RST;
            view_h_reg        <= WINDOW_HEIGHT_RST;
            ptr_x_reg         <= '0;
            ptr_y_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mul_start_reg     <= mul_start_next;
            div_start_reg     <= div_start_next;
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            pixel_width_reg   <= pixel_width_next;
            pixel_height_reg  <= pixel_height_next;
            win_w_reg         <= win_w_next;
            win_h_reg         <= win_h_next;
            view_left_reg     <= view_left_next;
            view_top_reg      <= view_top_next;
            view_w_reg        <= view_w_next;
            view_h_reg        <= view_h_next;
            ptr_x_reg         <= ptr_x_next;
            ptr_y_reg         <= ptr_y_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vw_tot_reg <= vw_tot_next;
        vh_tot_reg <= vh_tot_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        if (out_load)
        begin
            out_x_reg    <= ptr_x_reg;
            out_y_reg    <= ptr_y_reg;
            out_left_reg <= view_left_reg;
            out_top_reg  <= view_top_reg;
            out_w_reg    <= view_w_reg;
            out_h_reg    <= view_h_reg;
        end
    end

    assign evt.ready       = (state_reg == ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.screen_x    = out_x_reg;
    assign res.screen_y    = out_y_reg;
    assign res.view_left   = out_left_reg;
    assign res.view_top    = out_top_reg;
    assign res.view_width  = out_w_reg;
    assign res.view_height = out_h_reg;

    `ASSERT_CLK(a_mul_start_idle, mul_start_reg |-> !mul_stat.busy, "multiplier restarted while busy")
    `ASSERT_CLK(a_div_start_idle, div_start_reg |-> !div_stat.busy, "divider restarted while busy")
    `ASSERT_NEVER(a_single_unit_start, mul_start_reg && div_start_reg, "both units started at once")
    `ASSERT_CLK(a_out_from_load, $rose(out_valid_reg) |-> $past(state_reg == ST_OUT), "result valid without load")
    `ASSERT_CLK(a_view_in_window, (state_reg == ST_IDLE) |-> (view_w_reg <= win_w_reg && view_h_reg <= win_h_reg), "viewport exceeds window")

endmodule

`default_nettype wire
